// ----- design/wef_pkg.sv -----
package wef_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int MAX_WINDOW_DEF   = 4096;
    localparam int MIN_WINDOW       = 3;
    localparam int WINDOW_RESET     = 256;
    localparam int CFG_W            = 13;
    localparam int RESULT_W         = 16;

    localparam int NUM_FEAT    = 3;
    localparam int FEAT_CURVE  = 0;
    localparam int FEAT_ENERGY = 1;
    localparam int FEAT_TEAGER = 2;

    // log2 fraction format and ln2 scaling
    localparam int FRAC_W     = 10;
    localparam int TAB_W      = 11;
    localparam int TAB_IDX_W  = 5;
    localparam int LN2_Q16    = 45426;
    localparam int LN2_W      = 17;
    localparam int ROUND_HALF = 32768;
    localparam int SCALE_SH   = 16;

    typedef struct packed {
        logic                valid;
        logic [NUM_FEAT-1:0] invalid;
    } wef_fin_t;

    // round(1024 * log2(1 + k/16)) for k = 0..16
    function automatic logic [TAB_W-1:0] frac_entry(input logic [TAB_IDX_W-1:0] idx);
        logic [TAB_W-1:0] val;
        unique case (idx)
            5'd0:    val = 11'd0;
            5'd1:    val = 11'd90;
            5'd2:    val = 11'd174;
            5'd3:    val = 11'd254;
            5'd4:    val = 11'd330;
            5'd5:    val = 11'd402;
            5'd6:    val = 11'd470;
            5'd7:    val = 11'd536;
            5'd8:    val = 11'd599;
            5'd9:    val = 11'd659;
            5'd10:   val = 11'd717;
            5'd11:   val = 11'd773;
            5'd12:   val = 11'd827;
            5'd13:   val = 11'd879;
            5'd14:   val = 11'd929;
            5'd15:   val = 11'd977;
            5'd16:   val = 11'd1024;
            default: val = 11'd0;
        endcase
        return val;
    endfunction

endpackage

// ----- design/wef_accum.sv -----
module wef_accum #(
    parameter int  SAMPLE_WIDTH = wef_pkg::SAMPLE_WIDTH_DEF,
    parameter int  MAX_WINDOW   = wef_pkg::MAX_WINDOW_DEF,
    localparam int WIN_W        = $clog2(MAX_WINDOW + 1),
    localparam int ACC_EXT      = $clog2(MAX_WINDOW),
    localparam int ABS_W        = SAMPLE_WIDTH + ACC_EXT,
    localparam int SQ_W         = 2 * SAMPLE_WIDTH - 1 + ACC_EXT,
    localparam int TG_W         = 2 * SAMPLE_WIDTH + 1 + ACC_EXT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic [WIN_W-1:0]               win_eff,
    input  logic                           log_adv,
    output wef_pkg::wef_fin_t              fin,
    output logic [ABS_W-1:0]               fin_abs,
    output logic [SQ_W-1:0]                fin_sq,
    output logic [TG_W-2:0]                fin_tg,
    output logic [WIN_W-1:0]               fin_win
);
    import wef_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int PROD_W = 2 * SW;
    localparam int TERM_W = 2 * SW + 1;

    // window tracking at the input
    logic [WIN_W-1:0]       pos_reg;
    logic [WIN_W-1:0]       pos_inc;
    logic                   last_in;
    logic signed [SW-1:0]   prev_reg;
    logic signed [SW-1:0]   sprev_reg;
    logic                   accept;

    // stage A: registered sample and neighbors
    logic                   va_reg;
    logic signed [SW-1:0]   xa_reg;
    logic signed [SW-1:0]   pa_reg;
    logic signed [SW-1:0]   sa_reg;
    logic                   has1a_reg;
    logic                   has2a_reg;
    logic                   lasta_reg;
    logic [WIN_W-1:0]       wina_reg;

    // stage B: registered terms
    logic                   vb_reg;
    logic [SW-1:0]          absdb_reg;
    logic [PROD_W-2:0]      sqb_reg;
    logic signed [TERM_W-1:0] termb_reg;
    logic                   lastb_reg;
    logic [WIN_W-1:0]       winb_reg;

    logic                   adv_a;
    logic                   adv_b;
    logic                   consume_b;

    logic signed [SW:0]       diff;
    logic [SW:0]              abs_full;
    logic signed [PROD_W-1:0] sq_full;
    logic signed [PROD_W-1:0] pp_full;
    logic signed [PROD_W-1:0] xs_full;
    logic [SW-1:0]            absd_next;
    logic signed [TERM_W-1:0] term_next;

    logic [ABS_W-1:0]       abs_sum_reg;
    logic [SQ_W-1:0]        sq_sum_reg;
    logic [TG_W-1:0]        tg_sum_reg;
    logic [ABS_W-1:0]       abs_sum_next;
    logic [SQ_W-1:0]        sq_sum_next;
    logic [TG_W-1:0]        tg_sum_next;

    wef_fin_t               fin_reg;
    logic [ABS_W-1:0]       fin_abs_reg;
    logic [SQ_W-1:0]        fin_sq_reg;
    logic [TG_W-2:0]        fin_tg_reg;
    logic [WIN_W-1:0]       fin_win_reg;

    // a closing word needs room in the log pipe
    assign consume_b    = vb_reg && (!lastb_reg || log_adv);
    assign adv_b        = !vb_reg || consume_b;
    assign adv_a        = !va_reg || adv_b;
    assign sample_stall = !adv_a;
    assign accept       = sample_valid && adv_a;

    assign pos_inc = pos_reg + 1'b1;
    assign last_in = pos_inc >= win_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            prev_reg  <= '0;
            sprev_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= last_in ? '0 : pos_inc;
            prev_reg  <= sample;
            sprev_reg <= prev_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
                va_reg <= accept;
            if (adv_b)
                vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            xa_reg    <= sample;
            pa_reg    <= prev_reg;
            sa_reg    <= sprev_reg;
            has1a_reg <= pos_reg != '0;
            has2a_reg <= pos_reg > WIN_W'(1);
            lasta_reg <= last_in;
            wina_reg  <= win_eff;
        end
    end

    always_comb
    begin
        diff      = $signed({xa_reg[SW-1], xa_reg}) - $signed({pa_reg[SW-1], pa_reg});
        abs_full  = diff[SW] ? (SW + 1)'(-diff) : (SW + 1)'(diff);
        sq_full   = xa_reg * xa_reg;
        pp_full   = pa_reg * pa_reg;
        xs_full   = xa_reg * sa_reg;
        absd_next = has1a_reg ? abs_full[SW-1:0] : '0;
        term_next = has2a_reg ? ($signed({pp_full[PROD_W-1], pp_full})
                                 - $signed({xs_full[PROD_W-1], xs_full})) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv_b)
        begin
            absdb_reg <= absd_next;
            sqb_reg   <= sq_full[PROD_W-2:0];
            termb_reg <= term_next;
            lastb_reg <= lasta_reg;
            winb_reg  <= wina_reg;
        end
    end

    always_comb
    begin
        abs_sum_next = abs_sum_reg + ABS_W'(absdb_reg);
        sq_sum_next  = sq_sum_reg + SQ_W'(sqb_reg);
        tg_sum_next  = tg_sum_reg + {{(TG_W - TERM_W){termb_reg[TERM_W-1]}}, termb_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_sum_reg <= '0;
            sq_sum_reg  <= '0;
            tg_sum_reg  <= '0;
        end
        else if (consume_b)
        begin
            // clear at the window's end
            abs_sum_reg <= lastb_reg ? '0 : abs_sum_next;
            sq_sum_reg  <= lastb_reg ? '0 : sq_sum_next;
            tg_sum_reg  <= lastb_reg ? '0 : tg_sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_reg <= '0;
        else if (log_adv)
        begin
            fin_reg.valid                <= consume_b && lastb_reg;
            fin_reg.invalid[FEAT_CURVE]  <= abs_sum_next == '0;
            fin_reg.invalid[FEAT_ENERGY] <= sq_sum_next == '0;
            fin_reg.invalid[FEAT_TEAGER] <= (tg_sum_next == '0) || tg_sum_next[TG_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (log_adv)
        begin
            fin_abs_reg <= abs_sum_next;
            fin_sq_reg  <= sq_sum_next;
            fin_tg_reg  <= tg_sum_next[TG_W-2:0];
            fin_win_reg <= winb_reg;
        end
    end

    assign fin     = fin_reg;
    assign fin_abs = fin_abs_reg;
    assign fin_sq  = fin_sq_reg;
    assign fin_tg  = fin_tg_reg;
    assign fin_win = fin_win_reg;

endmodule

// ----- design/wef_log2.sv -----
module wef_log2 #(
    parameter int IN_W  = 45,
    parameter int OUT_W = 16
) (
    input  logic             clk,
    input  logic             en,
    input  logic [IN_W-1:0]  value,
    output logic [OUT_W-1:0] log_q10
);
    import wef_pkg::*;

    localparam int GRP   = 8;
    localparam int LOC_W = $clog2(GRP);
    localparam int NG    = (IN_W + GRP - 1) / GRP;
    localparam int PAD_W = NG * GRP;
    localparam int PW    = $clog2(PAD_W);
    localparam int EXT_W = PAD_W + FRAC_W;
    localparam int IDX_W = 4;
    localparam int REM_W = FRAC_W - IDX_W;

    logic [PAD_W-1:0]            val_pad;
    logic [NG-1:0]               nz_next;
    logic [NG-1:0][LOC_W-1:0]    loc_next;

    logic [PAD_W-1:0]            val1_reg;
    logic [NG-1:0]               nz1_reg;
    logic [NG-1:0][LOC_W-1:0]    loc1_reg;

    logic [PW-1:0]               p_next;
    logic [PW-1:0]               p2_reg;
    logic [PAD_W-1:0]            val2_reg;

    logic [EXT_W-1:0]            ext_sh;
    logic [FRAC_W-1:0]           mant;
    logic [IDX_W-1:0]            tab_i;
    logic [REM_W-1:0]            tab_r;
    logic [TAB_W-1:0]            lo;
    logic [TAB_W-1:0]            hi;
    logic [TAB_W-1:0]            slope;
    logic [TAB_W+REM_W-1:0]      interp;
    logic [OUT_W-1:0]            log_next;
    logic [OUT_W-1:0]            log_reg;

    assign val_pad = PAD_W'(value);

    // stage 1: leading one inside each byte
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            nz_next[g]  = |val_pad[g*GRP +: GRP];
            loc_next[g] = '0;
            for (int b = 0; b < GRP; b++)
                if (val_pad[g*GRP + b])
                    loc_next[g] = LOC_W'(b);
        end
    end

    // stage 2: leading-one position from the highest nonzero byte
    always_comb
    begin
        p_next = '0;
        for (int g = 0; g < NG; g++)
            if (nz1_reg[g])
                p_next = PW'(g * GRP) + PW'(loc1_reg[g]);
    end

    // stage 3: ten bits below the leading one, table with linear interpolation
    always_comb
    begin
        ext_sh   = {val2_reg, {FRAC_W{1'b0}}} >> p2_reg;
        mant     = ext_sh[FRAC_W-1:0];
        tab_i    = mant[FRAC_W-1:REM_W];
        tab_r    = mant[REM_W-1:0];
        lo       = frac_entry(TAB_IDX_W'(tab_i));
        hi       = frac_entry(TAB_IDX_W'(tab_i) + TAB_IDX_W'(1));
        slope    = hi - lo;
        interp   = slope * tab_r;
        log_next = OUT_W'({p2_reg, {FRAC_W{1'b0}}}) + OUT_W'(lo)
                   + OUT_W'(interp[TAB_W+REM_W-1:REM_W]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val1_reg <= val_pad;
            nz1_reg  <= nz_next;
            loc1_reg <= loc_next;
            p2_reg   <= p_next;
            val2_reg <= val1_reg;
            log_reg  <= log_next;
        end
    end

    assign log_q10 = log_reg;

endmodule

// ----- design/window_energy_features_unit.sv -----
// Window energy features: takes one signed sample per word on the sample
// channel and splits the stream into back-to-back windows of window_size
// samples (clamped to 3..MAX_WINDOW). Per window it accumulates the absolute
// first differences, the squares and the Teager terms, and after the last
// sample emits one result word: ln(sum / window) of each in signed Q6.10,
// plus invalid_flags for any sum that is not positive (its field reads 0).
// Channels: sample and result use valid/stall, a word moves at an edge with
// valid high and stall low. window_size is written through cfg_valid/ready,
// always ready; write it only while no window result is pending.
// Throughput: one sample per cycle while sample_stall is low. The result is
// registered after two input stages, the accumulators, a three-stage log2
// unit, the ln2 scaling multiplier and the rounding output register.
// While result_stall holds a valid result, the log pipe freezes; samples that
// do not close a window keep flowing, and sample_stall rises only when a
// closing sample meets the frozen pipe.
// Reset clears the sums, the window position and the sample history, and
// sets window_size to 256.
module window_energy_features_unit #(
    parameter int SAMPLE_WIDTH = wef_pkg::SAMPLE_WIDTH_DEF,
    parameter int MAX_WINDOW   = wef_pkg::MAX_WINDOW_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wef_pkg::CFG_W-1:0]          window_size,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [wef_pkg::RESULT_W-1:0] curve_length_log,
    output logic signed [wef_pkg::RESULT_W-1:0] energy_log,
    output logic signed [wef_pkg::RESULT_W-1:0] teager_log,
    output logic [wef_pkg::NUM_FEAT-1:0]       invalid_flags
);
    import wef_pkg::*;

    localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
    localparam int ACC_EXT = $clog2(MAX_WINDOW);
    localparam int ABS_W   = SAMPLE_WIDTH + ACC_EXT;
    localparam int SQ_W    = 2 * SAMPLE_WIDTH - 1 + ACC_EXT;
    localparam int TG_W    = 2 * SAMPLE_WIDTH + 1 + ACC_EXT;
    localparam int LOG_W   = $clog2(TG_W * 1024);
    localparam int D_W     = LOG_W + 1;
    localparam int PROD_W  = D_W + LN2_W;
    localparam int Q_W     = PROD_W - SCALE_SH;

    logic [CFG_W-1:0]       window_size_reg;
    logic [31:0]            cfg_wide;
    logic [WIN_W-1:0]       win_eff;
    logic                   log_adv;

    wef_fin_t               fin;
    logic [ABS_W-1:0]       fin_abs;
    logic [SQ_W-1:0]        fin_sq;
    logic [TG_W-2:0]        fin_tg;
    logic [WIN_W-1:0]       fin_win;

    logic [NUM_FEAT-1:0][LOG_W-1:0] lg;
    logic [LOG_W-1:0]               lw;

    logic                   v1_reg, v2_reg, v3_reg, vm_reg, result_valid_reg;
    logic [NUM_FEAT-1:0]    fl1_reg, fl2_reg, fl3_reg, flm_reg, flags_reg;

    logic signed [D_W-1:0]    d       [NUM_FEAT];
    logic signed [PROD_W-1:0] prod_next [NUM_FEAT];
    logic signed [PROD_W-1:0] prod_reg  [NUM_FEAT];
    logic signed [PROD_W-1:0] rnd     [NUM_FEAT];
    logic signed [Q_W-1:0]    q       [NUM_FEAT];
    logic [RESULT_W-1:0]      res_next [NUM_FEAT];
    logic [RESULT_W-1:0]      res_reg  [NUM_FEAT];

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_size_reg <= CFG_W'(WINDOW_RESET);
        else if (cfg_valid && cfg_ready)
            window_size_reg <= window_size;
    end

    always_comb
    begin
        cfg_wide = 32'(window_size_reg);
        priority if (cfg_wide < 32'(MIN_WINDOW))
            win_eff = WIN_W'(MIN_WINDOW);
        else if (cfg_wide > 32'(MAX_WINDOW))
            win_eff = WIN_W'(MAX_WINDOW);
        else
            win_eff = WIN_W'(cfg_wide);
    end

    // the whole log pipe moves together unless the result word is held
    assign log_adv = !result_valid_reg || !result_stall;

    wef_accum #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .win_eff      (win_eff),
        .log_adv      (log_adv),
        .fin          (fin),
        .fin_abs      (fin_abs),
        .fin_sq       (fin_sq),
        .fin_tg       (fin_tg),
        .fin_win      (fin_win)
    );

    wef_log2 #(.IN_W(ABS_W), .OUT_W(LOG_W)) u_log_curve (
        .clk (clk), .en (log_adv), .value (fin_abs), .log_q10 (lg[FEAT_CURVE])
    );

    wef_log2 #(.IN_W(SQ_W), .OUT_W(LOG_W)) u_log_energy (
        .clk (clk), .en (log_adv), .value (fin_sq), .log_q10 (lg[FEAT_ENERGY])
    );

    wef_log2 #(.IN_W(TG_W - 1), .OUT_W(LOG_W)) u_log_teager (
        .clk (clk), .en (log_adv), .value (fin_tg), .log_q10 (lg[FEAT_TEAGER])
    );

    wef_log2 #(.IN_W(WIN_W), .OUT_W(LOG_W)) u_log_window (
        .clk (clk), .en (log_adv), .value (fin_win), .log_q10 (lw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            vm_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (log_adv)
        begin
            v1_reg           <= fin.valid;
            v2_reg           <= v1_reg;
            v3_reg           <= v2_reg;
            vm_reg           <= v3_reg;
            result_valid_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (log_adv)
        begin
            fl1_reg   <= fin.invalid;
            fl2_reg   <= fl1_reg;
            fl3_reg   <= fl2_reg;
            flm_reg   <= fl3_reg;
            flags_reg <= flm_reg;
        end
    end

    // ln = (log2(sum) - log2(window)) * ln2, rounded to nearest, saturated, 0 when flagged
    for (genvar k = 0; k < NUM_FEAT; k++)
    begin : g_scale
        always_comb
        begin
            d[k]         = $signed({1'b0, lg[k]}) - $signed({1'b0, lw});
            prod_next[k] = d[k] * $signed(LN2_W'(LN2_Q16));
            rnd[k]       = prod_reg[k] + PROD_W'(ROUND_HALF);
            q[k]         = rnd[k][PROD_W-1:SCALE_SH];
            priority if (flm_reg[k])
                res_next[k] = '0;
            else if (q[k] > $signed(Q_W'(32767)))
                res_next[k] = RESULT_W'(32767);
            else if (q[k] < -$signed(Q_W'(32768)))
                res_next[k] = RESULT_W'(-32768);
            else
                res_next[k] = q[k][RESULT_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (log_adv)
            begin
                prod_reg[k] <= prod_next[k];
                res_reg[k]  <= res_next[k];
            end
        end
    end

    assign result_valid     = result_valid_reg;
    assign curve_length_log = res_reg[FEAT_CURVE];
    assign energy_log       = res_reg[FEAT_ENERGY];
    assign teager_log       = res_reg[FEAT_TEAGER];
    assign invalid_flags    = flags_reg;

`ifndef NO_ASSERTIONS
    // an all-zero window has no differences and no Teager energy either
    a_zero_energy_window : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && invalid_flags[FEAT_ENERGY]
        |-> invalid_flags[FEAT_CURVE] && invalid_flags[FEAT_TEAGER])
        else $error("energy flagged without curve and teager flags");

    // input back-pressure only comes from a held result word
    a_stall_source : assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid && result_stall)
        else $error("sample_stall raised without a held result");
`endif

endmodule
